// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. Defining ASSERT_OFF
// compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

// ----- hdl/fqu_pkg.sv -----
// ----------------------------------------------------------------------------
// fqu_pkg
// Types, codes and the microprogram of the unique-key FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fqu_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned KEY_W        = 31;
  localparam int unsigned PAY_W        = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned UPC_W        = 4;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_PEEK   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Datapath actions of one microstep.
  typedef enum logic [3:0] {
    A_NONE,
    A_FETCH,
    A_SCAN_INIT,
    A_SCAN,
    A_INS_WRITE,
    A_RES_DUP,
    A_RES_FULL,
    A_RES_NOT_FOUND,
    A_RES_HIT,
    A_RD_HEAD,
    A_RES_POP,
    A_RES_EMPTY,
    A_RES_PEEK
  } act_e;

  // Sequencing conditions of one microstep.
  typedef enum logic [2:0] {
    C_NEXT,
    C_FETCH,
    C_SCAN,
    C_FULL,
    C_EMPTY,
    C_POST
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  // Microprogram step addresses.
  localparam upc_t S_FETCH    = upc_t'(0);
  localparam upc_t S_INS_INIT = upc_t'(1);
  localparam upc_t S_INS_SCAN = upc_t'(2);
  localparam upc_t S_INS_CHK  = upc_t'(3);
  localparam upc_t S_INS_WR   = upc_t'(4);
  localparam upc_t S_INS_DUP  = upc_t'(5);
  localparam upc_t S_INS_FULL = upc_t'(6);
  localparam upc_t S_SRC_INIT = upc_t'(7);
  localparam upc_t S_SRC_SCAN = upc_t'(8);
  localparam upc_t S_SRC_MISS = upc_t'(9);
  localparam upc_t S_SRC_HIT  = upc_t'(10);
  localparam upc_t S_RM_CHK   = upc_t'(11);
  localparam upc_t S_RM_POP   = upc_t'(12);
  localparam upc_t S_EMPTY    = upc_t'(13);
  localparam upc_t S_PK_CHK   = upc_t'(14);
  localparam upc_t S_PK_OUT   = upc_t'(15);

  // Control store. A step jumps to its target when its condition holds
  // and otherwise falls through to the next step or waits in place.
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    case (pc)
      S_FETCH:    w = '{A_FETCH,         C_FETCH, S_FETCH};
      S_INS_INIT: w = '{A_SCAN_INIT,     C_NEXT,  S_FETCH};
      S_INS_SCAN: w = '{A_SCAN,          C_SCAN,  S_INS_DUP};
      S_INS_CHK:  w = '{A_NONE,          C_FULL,  S_INS_FULL};
      S_INS_WR:   w = '{A_INS_WRITE,     C_POST,  S_FETCH};
      S_INS_DUP:  w = '{A_RES_DUP,       C_POST,  S_FETCH};
      S_INS_FULL: w = '{A_RES_FULL,      C_POST,  S_FETCH};
      S_SRC_INIT: w = '{A_SCAN_INIT,     C_NEXT,  S_FETCH};
      S_SRC_SCAN: w = '{A_SCAN,          C_SCAN,  S_SRC_HIT};
      S_SRC_MISS: w = '{A_RES_NOT_FOUND, C_POST,  S_FETCH};
      S_SRC_HIT:  w = '{A_RES_HIT,       C_POST,  S_FETCH};
      S_RM_CHK:   w = '{A_RD_HEAD,       C_EMPTY, S_EMPTY};
      S_RM_POP:   w = '{A_RES_POP,       C_POST,  S_FETCH};
      S_EMPTY:    w = '{A_RES_EMPTY,     C_POST,  S_FETCH};
      S_PK_CHK:   w = '{A_RD_HEAD,       C_EMPTY, S_EMPTY};
      S_PK_OUT:   w = '{A_RES_PEEK,      C_POST,  S_FETCH};
      default:    w = '{A_FETCH,         C_FETCH, S_FETCH};
    endcase
    return w;
  endfunction

  // Entry step of the routine for each request kind.
  function automatic upc_t dispatch(input req_e req);
    upc_t pc;
    case (req)
      REQ_INSERT: pc = S_INS_INIT;
      REQ_REMOVE: pc = S_RM_CHK;
      REQ_SEARCH: pc = S_SRC_INIT;
      REQ_PEEK:   pc = S_PK_CHK;
      default:    pc = S_FETCH;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fqu_if.sv -----
// ----------------------------------------------------------------------------
// fqu_if
// Valid/ready channels of the unique-key FIFO queue: requests in,
// results out.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel.
interface fqu_req_if import fqu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output req_type, output key, output payload,
                  input ready);
  modport sink   (input valid, input req_type, input key, input payload,
                  output ready);
endinterface

// Result channel.
interface fqu_rsp_if import fqu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    found_key;
  logic [PAY_W-1:0]    found_payload;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;

  modport source (output valid, output status, output found_key,
                  output found_payload, output count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input found_key,
                  input found_payload, input count, input is_empty,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/fqu_store.sv -----
// ----------------------------------------------------------------------------
// fqu_store
// Entry storage: one key and payload per slot, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fqu_store import fqu_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned IDX_W = $clog2(CAPACITY_DEF)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [KEY_W-1:0] wkey_i,
  input  logic [PAY_W-1:0] wpay_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [KEY_W-1:0] rkey_o,
  output logic [PAY_W-1:0] rpay_o
);

  logic [KEY_W+PAY_W-1:0] mem_q [DEPTH];
  logic [KEY_W+PAY_W-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wkey_i, wpay_i};
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rkey_o = rd_q[KEY_W+PAY_W-1:PAY_W];
  assign rpay_o = rd_q[PAY_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/fifo_queue_unique_key_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_unique_key_unit
// Bounded FIFO of key/payload records that refuses duplicate keys, run by
// a microcoded sequencer over a one-write, one-read-port entry store.
//
//   Channel  Dir  Beat contents
//   req_i    in   req_type, key, payload
//   rsp_o    out  status, found_key, found_payload, count, is_empty
//
// Insert and search scan the held entries one per cycle through the store
// read port; a match ends the scan early.
// Reset empties the queue at once; no clearing pass.
// A result beat waits in the output register; the next request is taken
// meanwhile, and its result step stalls until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fifo_queue_unique_key_unit import fqu_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqu_req_if.sink     req_i,
  fqu_rsp_if.source   rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Slot after a given one, wrapping at the capacity.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(CAPACITY - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

  // Sequencer and queue state.
  upc_t             upc_q, upc_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [PAY_W-1:0]    out_pay_q, out_pay_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_empty_q, out_empty_d;

  // Store ports.
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;

  ucode_t                 uw;
  logic                   in_fire, post_ok, res_fire, res_post, match;
  logic                   scan_done, full, empty;
  status_e                res_status;
  logic                   res_data;
  logic [IDX_W:0]         tail_sum;
  logic [IDX_W-1:0]       tail_idx;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign uw        = ucode_rom(upc_q);
  assign in_fire   = req_i.valid && req_i.ready;
  assign post_ok   = !out_valid_q || rsp_o.ready;
  assign match     = pend_q && (rd_key == key_q);
  assign scan_done = (scan_cnt_q == held_q);
  assign full      = (held_q == CNT_W'(CAPACITY));
  assign empty     = (held_q == '0);
  assign res_fire  = res_post && post_ok;

  // Tail slot, where the next insert lands.
  assign tail_sum = {1'b0, head_q} + (IDX_W+1)'(held_q);
  assign tail_idx = (tail_sum >= (IDX_W+1)'(CAPACITY))
                  ? IDX_W'(tail_sum - (IDX_W+1)'(CAPACITY))
                  : tail_sum[IDX_W-1:0];

  assign req_i.ready = (uw.act == A_FETCH);

  // Datapath actions of the current step.
  always_comb begin
    head_d     = head_q;
    held_d     = held_q;
    pend_d     = pend_q;
    scan_ptr_d = scan_ptr_q;
    scan_cnt_d = scan_cnt_q;
    key_d      = key_q;
    pay_d      = pay_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = scan_ptr_q;
    res_post   = 1'b0;
    res_status = ST_OK;
    res_data   = 1'b0;
    case (uw.act)
      A_FETCH: begin
        if (in_fire) begin
          key_d = req_i.key;
          pay_d = req_i.payload;
        end
      end
      A_SCAN_INIT: begin
        scan_ptr_d = head_q;
        scan_cnt_d = '0;
        pend_d     = 1'b0;
      end
      A_SCAN: begin
        // Compare last cycle's entry while reading the next one.
        if (!match && !scan_done) begin
          mem_re     = 1'b1;
          scan_ptr_d = next_idx(scan_ptr_q);
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
        end
      end
      A_INS_WRITE: begin
        res_post = 1'b1;
        if (post_ok) begin
          mem_we = 1'b1;
          held_d = held_q + CNT_W'(1);
        end
      end
      A_RES_DUP: begin
        res_post   = 1'b1;
        res_status = ST_DUP;
      end
      A_RES_FULL: begin
        res_post   = 1'b1;
        res_status = ST_FULL;
      end
      A_RES_NOT_FOUND: begin
        res_post   = 1'b1;
        res_status = ST_NOT_FOUND;
      end
      A_RES_EMPTY: begin
        res_post   = 1'b1;
        res_status = ST_EMPTY;
      end
      A_RES_HIT, A_RES_PEEK: begin
        res_post = 1'b1;
        res_data = 1'b1;
      end
      A_RD_HEAD: begin
        if (!empty) begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
        end
      end
      A_RES_POP: begin
        res_post = 1'b1;
        res_data = 1'b1;
        if (post_ok) begin
          head_d = next_idx(head_q);
          held_d = held_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Count field as seen after the request.
  assign cnt_ext = {{COUNT_W{1'b0}}, held_d};

  // Output register: load on a posted result, clear when the beat is taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_pay_d    = out_pay_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    if (res_fire) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_key_d    = res_data ? rd_key : '0;
      out_pay_d    = res_data ? rd_pay : '0;
      out_count_d  = cnt_ext[COUNT_W-1:0];
      out_empty_d  = (held_d == '0);
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Step sequencing.
  always_comb begin
    case (uw.cond)
      C_NEXT:  upc_d = upc_q + upc_t'(1);
      C_FETCH: upc_d = in_fire ? dispatch(req_e'(req_i.req_type)) : upc_q;
      C_SCAN: begin
        if (match) begin
          upc_d = uw.target;
        end else if (scan_done) begin
          upc_d = upc_q + upc_t'(1);
        end else begin
          upc_d = upc_q;
        end
      end
      C_FULL:  upc_d = full ? uw.target : upc_q + upc_t'(1);
      C_EMPTY: upc_d = empty ? uw.target : upc_q + upc_t'(1);
      C_POST:  upc_d = post_ok ? uw.target : upc_q;
      default: upc_d = S_FETCH;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_FETCH;
      head_q      <= '0;
      held_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      head_q      <= head_d;
      held_q      <= held_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    scan_ptr_q   <= scan_ptr_d;
    scan_cnt_q   <= scan_cnt_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_pay_q    <= out_pay_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  fqu_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_idx),
    .wkey_i  (key_q),
    .wpay_i  (pay_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rkey_o  (rd_key),
    .rpay_o  (rd_pay)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.found_key     = out_key_q;
  assign rsp_o.found_payload = out_pay_q;
  assign rsp_o.count         = out_count_q;
  assign rsp_o.is_empty      = out_empty_q;

  // The held count never passes the capacity.
  `ASSERT_CLK(a_held_bound, clk_i, rst_ni, held_q <= CNT_W'(CAPACITY))
  // An accepted request always moves the sequencer into a routine.
  `ASSERT_CLK(a_fetch_leaves, clk_i, rst_ni, in_fire |=> upc_q != S_FETCH)
  // A delivered pop lowers the count by exactly one.
  `ASSERT_CLK(a_pop_count, clk_i, rst_ni, (uw.act == A_RES_POP && res_fire) |=> held_q == $past(held_q) - CNT_W'(1))
  // A scan never reads past the held entries.
  `ASSERT_CLK(a_scan_bound, clk_i, rst_ni, (uw.act == A_SCAN) |-> scan_cnt_q <= held_q)
  // Nothing is written into a full queue.
  `ASSERT_NEVER(a_write_full, clk_i, rst_ni, mem_we && full)

endmodule

`default_nettype wire
